// File: design/calendar_minute_offset_adder_top_defines.svh
// Assertion macros for the calendar offset adder.
// Included by the top level; no other dependencies.
`ifndef CALENDAR_MINUTE_OFFSET_ADDER_TOP_DEFINES_SVH
`define CALENDAR_MINUTE_OFFSET_ADDER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/cmoa_pkg.sv
// Shared types, constants and calendar functions for the calendar offset adder.
// No dependencies.
package cmoa_pkg;

   localparam logic [1:0] KIND_MINUTES = 2'd0;
   localparam logic [1:0] KIND_HOURS   = 2'd1;

   localparam logic [3:0] MONTH_JAN = 4'd0;
   localparam logic [3:0] MONTH_FEB = 4'd1;
   localparam logic [3:0] MONTH_DEC = 4'd11;

   localparam logic [9:0] YEAR_LAST = 10'd1023;

   localparam int DIV_WIDTH   = 17;
   localparam int RECIP_WIDTH = 19;
   localparam int RECIP_SHIFT = 23;
   localparam int PROD_WIDTH  = DIV_WIDTH + RECIP_WIDTH;

   // ceil(2^23 / divisor), exact for every dividend below 2^17
   localparam logic [RECIP_WIDTH-1:0] RECIP_60 = 19'd139811;
   localparam logic [RECIP_WIDTH-1:0] RECIP_24 = 19'd349526;
   localparam logic [DIV_WIDTH-1:0]   DSR_60   = 17'd60;
   localparam logic [DIV_WIDTH-1:0]   DSR_24   = 17'd24;

   // bias = divisor * k keeps floor division on a non-negative dividend
   localparam logic signed [17:0] MIN_BIAS    = 18'sd32820;
   localparam logic signed [17:0] MIN_BIAS_Q  = 18'sd547;
   localparam logic signed [17:0] HOUR_BIAS   = 18'sd32784;
   localparam logic signed [17:0] HOUR_BIAS_Q = 18'sd1366;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] amount;
      logic [9:0]         start_year;
      logic [3:0]         start_month;
      logic [4:0]         start_day;
      logic [4:0]         start_hour;
      logic [5:0]         start_minute;
   } req_type;

   typedef struct packed {
      logic [9:0] new_year;
      logic [3:0] new_month;
      logic [4:0] new_day;
      logic [4:0] new_hour;
      logic [5:0] new_minute;
      logic       year_overflow;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_sel24;
      logic take_min;
      logic take_hour;
      logic walk_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       div_busy;
      logic       walk_done;
   } sts_type;

   function automatic logic leap_year(input logic [9:0] y);
      logic cent;
      logic quad;
      begin
         cent = 1'b0;
         for (int k = 0; k <= 10; k++) begin
            if (y == 10'(k * 100)) begin
               cent = 1'b1;
            end
         end
         quad = (y == 10'd100) || (y == 10'd500) || (y == 10'd900);
         return ((y[1:0] == 2'b00) && !cent) || quad;
      end
   endfunction

   function automatic logic [4:0] days_in(input logic [3:0] m, input logic [9:0] y);
      logic [4:0] len;
      begin
         case (m)
            4'd1:    len = 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
         endcase
         if ((m == MONTH_FEB) && leap_year(y)) begin
            len = 5'd29;
         end
         return len;
      end
   endfunction

endpackage

// File: design/cmoa_cdiv.sv
// Divider by a constant divisor of 60 or 24 through reciprocal multiplication:
// the quotient is registered first, the remainder after it. Depends on cmoa_pkg.
module cmoa_cdiv
   import cmoa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 sel24,
   input  logic [DIV_WIDTH-1:0] dividend,
   output logic                 busy,
   output logic [DIV_WIDTH-1:0] quotient,
   output logic [5:0]           remainder
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_QUO  = 2'd1;
   localparam logic [1:0] PH_REM  = 2'd2;

   logic [1:0]             phase_ff, phase_in;
   logic [DIV_WIDTH-1:0]   num_ff, num_in;
   logic [DIV_WIDTH-1:0]   quo_ff, quo_in;
   logic [5:0]             rem_ff, rem_in;
   logic                   sel_ff, sel_in;
   logic [RECIP_WIDTH-1:0] recip;
   logic [PROD_WIDTH-1:0]  prod;
   logic [DIV_WIDTH-1:0]   dsr;
   logic [DIV_WIDTH-1:0]   back;
   logic [DIV_WIDTH-1:0]   diff;

   always_comb begin
      recip    = sel_ff ? RECIP_24 : RECIP_60;
      dsr      = sel_ff ? DSR_24 : DSR_60;
      prod     = {{RECIP_WIDTH{1'b0}}, num_ff} * {{DIV_WIDTH{1'b0}}, recip};
      back     = quo_ff * dsr;
      diff     = num_ff - back;
      phase_in = phase_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      sel_in   = sel_ff;
      if (start) begin
         phase_in = PH_QUO;
         num_in   = dividend;
         sel_in   = sel24;
      end else begin
         case (phase_ff)
            PH_QUO: begin
               quo_in   = DIV_WIDTH'(prod[PROD_WIDTH-1:RECIP_SHIFT]);
               phase_in = PH_REM;
            end
            PH_REM: begin
               rem_in   = diff[5:0];
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      sel_ff <= sel_in;
   end

   assign busy      = (phase_ff != PH_IDLE);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: design/cmoa_datapath.sv
// Datapath: field registers, minute/hour wrap through the shared divider,
// month walk and the result register. Depends on cmoa_pkg and cmoa_cdiv.
module cmoa_datapath
   import cmoa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output sts_type sts,
   output rsp_type rsp_data
);

   req_type              raw_ff, raw_in;
   logic [9:0]           y_ff, y_in;
   logic [3:0]           m_ff, m_in;
   logic signed [17:0]   d_ff, d_in;
   logic [4:0]           h_ff, h_in;
   logic [5:0]           mi_ff, mi_in;
   logic signed [17:0]   carry_ff, carry_in;
   logic                 ovf_ff, ovf_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 div_busy;
   logic [DIV_WIDTH-1:0] div_quot;
   logic [5:0]           div_rem;
   logic [DIV_WIDTH-1:0] dividend;
   logic signed [17:0]   min_sum;
   logic signed [17:0]   hour_sum;
   logic signed [17:0]   quot_x;
   logic signed [17:0]   amt_x;
   logic signed [17:0]   raw_amt_x;

   logic                 mi_wrap;
   logic [5:0]           hv;
   logic                 h_wrap;
   logic [4:0]           dim_cur;
   logic [3:0]           m_prev;
   logic [9:0]           y_prev;
   logic [4:0]           dim_prev;
   logic                 d_pos;
   logic                 d_fits;
   logic                 walk_done;
   rsp_type              result;

   always_comb begin
      raw_amt_x = {{2{raw_ff.amount[15]}}, raw_ff.amount};
      min_sum   = 18'(raw_ff.start_minute) + raw_amt_x + MIN_BIAS;
      hour_sum  = 18'(raw_ff.start_hour) + carry_ff + HOUR_BIAS;
      dividend  = cmd.div_sel24 ? hour_sum[DIV_WIDTH-1:0] : min_sum[DIV_WIDTH-1:0];
   end

   cmoa_cdiv u_cdiv (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .sel24     (cmd.div_sel24),
      .dividend  (dividend),
      .busy      (div_busy),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_comb begin
      amt_x   = {{2{req_data.amount[15]}}, req_data.amount};
      mi_wrap = (req_data.start_minute >= 6'd60);
      hv      = {1'b0, req_data.start_hour} + {5'd0, mi_wrap};
      h_wrap  = (hv >= 6'd24);
      quot_x  = {1'b0, div_quot};

      dim_cur  = days_in(m_ff, y_ff);
      m_prev   = (m_ff == MONTH_JAN) ? MONTH_DEC : m_ff - 4'd1;
      y_prev   = (m_ff == MONTH_JAN) ? y_ff - 10'd1 : y_ff;
      dim_prev = days_in(m_prev, y_prev);
      d_pos    = !d_ff[17] && (d_ff != 18'sd0);
      d_fits   = d_ff <= $signed({13'd0, dim_cur});
      walk_done = ovf_ff || (d_pos && d_fits);

      raw_in   = raw_ff;
      y_in     = y_ff;
      m_in     = m_ff;
      d_in     = d_ff;
      h_in     = h_ff;
      mi_in    = mi_ff;
      carry_in = carry_ff;
      ovf_in   = ovf_ff;

      if (cmd.load) begin
         raw_in   = req_data;
         y_in     = req_data.start_year;
         m_in     = (req_data.start_month > MONTH_DEC) ? MONTH_DEC : req_data.start_month;
         mi_in    = mi_wrap ? req_data.start_minute - 6'd60 : req_data.start_minute;
         h_in     = h_wrap ? 5'(hv - 6'd24) : hv[4:0];
         d_in     = 18'(req_data.start_day) + amt_x + 18'(h_wrap);
         carry_in = amt_x + 18'(mi_wrap);
         ovf_in   = 1'b0;
      end

      if (cmd.take_min) begin
         mi_in    = div_rem;
         carry_in = quot_x - MIN_BIAS_Q;
      end

      if (cmd.take_hour) begin
         h_in = div_rem[4:0];
         d_in = 18'(raw_ff.start_day) + quot_x - HOUR_BIAS_Q;
      end

      if (cmd.walk_step && !walk_done) begin
         if (d_pos) begin
            // advance one month
            d_in = d_ff - 18'(dim_cur);
            if (m_ff == MONTH_DEC) begin
               if (y_ff == YEAR_LAST) begin
                  ovf_in = 1'b1;
               end else begin
                  m_in = MONTH_JAN;
                  y_in = y_ff + 10'd1;
               end
            end else begin
               m_in = m_ff + 4'd1;
            end
         end else begin
            // step back one month
            if ((m_ff == MONTH_JAN) && (y_ff == 10'd0)) begin
               ovf_in = 1'b1;
            end else begin
               m_in = m_prev;
               y_in = y_prev;
               d_in = d_ff + 18'(dim_prev);
            end
         end
      end

      if (ovf_ff) begin
         result.new_year   = raw_ff.start_year;
         result.new_month  = raw_ff.start_month;
         result.new_day    = raw_ff.start_day;
         result.new_hour   = raw_ff.start_hour;
         result.new_minute = raw_ff.start_minute;
      end else begin
         result.new_year   = y_ff;
         result.new_month  = m_ff;
         result.new_day    = d_ff[4:0];
         result.new_hour   = h_ff;
         result.new_minute = mi_ff;
      end
      result.year_overflow = ovf_ff;

      rsp_in = cmd.emit ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      raw_ff   <= raw_in;
      y_ff     <= y_in;
      m_ff     <= m_in;
      d_ff     <= d_in;
      h_ff     <= h_in;
      mi_ff    <= mi_in;
      carry_ff <= carry_in;
      ovf_ff   <= ovf_in;
      rsp_ff   <= rsp_in;
   end

   assign sts.kind      = raw_ff.kind;
   assign sts.div_busy  = div_busy;
   assign sts.walk_done = walk_done;
   assign rsp_data      = rsp_ff;

endmodule

// File: design/cmoa_ctrl.sv
// Controller: sequences load, minute and hour division, month walk and
// result hand-off. Depends on cmoa_pkg.
module cmoa_ctrl
   import cmoa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_DIVM  = 3'd2;
   localparam logic [2:0] S_SETH  = 3'd3;
   localparam logic [2:0] S_DIVH  = 3'd4;
   localparam logic [2:0] S_WALK  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      out_free = !rsp_valid_ff || !rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            if (sts.kind == KIND_MINUTES) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVM;
            end else if (sts.kind == KIND_HOURS) begin
               state_in = S_SETH;
            end else begin
               state_in = S_WALK;
            end
         end
         S_DIVM: begin
            if (!sts.div_busy) begin
               cmd.take_min = 1'b1;
               state_in     = S_SETH;
            end
         end
         S_SETH: begin
            cmd.div_start = 1'b1;
            cmd.div_sel24 = 1'b1;
            state_in      = S_DIVH;
         end
         S_DIVH: begin
            if (!sts.div_busy) begin
               cmd.take_hour = 1'b1;
               state_in      = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_done && out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/calendar_minute_offset_adder_top.sv
// Calendar offset adder: adds a signed offset in minutes, hours or days to a
// date and time (years since 1900) and returns the normalized date and time,
// or the start fields with year_overflow set if the year leaves 0..1023.
// One transaction is worked at a time. A minute offset runs a constant
// division by 60 and then one by 24, an hour offset only the one by 24 and
// a day offset neither; each then walks month by month until the day fits.
// Each division goes through reciprocal multiply, remainder and take, and the
// month walk advances one month a cycle. The result shows in the cycle in
// which the next transaction can be taken. The result sits in an output
// register, so a new transaction is taken while the previous result still
// waits; its own result is then held back until the register frees up.
// Depends on cmoa_pkg, cmoa_ctrl, cmoa_datapath.
`include "calendar_minute_offset_adder_top_defines.svh"
module calendar_minute_offset_adder_top
   import cmoa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   cmoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cmoa_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   `ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_NXT(a_emit_shows_result, clock, reset, cmd.emit, rsp_valid)
   `ASSERT_IMP(a_day_in_range, clock, reset, rsp_valid && !rsp_data.year_overflow, (rsp_data.new_day != 5'd0) && (rsp_data.new_month <= MONTH_DEC))
   `ASSERT_IMP(a_time_in_range, clock, reset, rsp_valid && !rsp_data.year_overflow, (rsp_data.new_hour < 5'd24) && (rsp_data.new_minute < 6'd60))

endmodule
